### rtl/spq_pkg.sv
package spq_pkg;

    localparam int unsigned PC_COUNT   = 12;
    localparam int unsigned ROM_DEPTH  = 35;
    localparam int unsigned NUM_SCALES = 35;
    localparam int unsigned SEL_W      = 6;
    localparam int unsigned ROOT_W     = 4;
    localparam int unsigned NOTE_IN_W  = 8;
    localparam int unsigned NOTE_OUT_W = 9;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 6;
    localparam int unsigned STAGES     = 5;

    typedef logic [PC_COUNT-1:0] mask_t;
    typedef logic [3:0]          pc_t;
    typedef logic signed [4:0]   offset_t;

    localparam mask_t FULL_MASK = 12'h0FFF;
    localparam mask_t EMPTY_MASK = 12'h0000;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE_SELECT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROOT_NOTE    = 1'b1;

    function automatic mask_t rom_mask(input logic [SEL_W-1:0] sel);
        mask_t m;
        case (sel)
            6'd0:    m = 12'h0FFF;
            6'd1:    m = 12'h0AB5;
            6'd2:    m = 12'h06AD;
            6'd3:    m = 12'h05AB;
            6'd4:    m = 12'h0AD5;
            6'd5:    m = 12'h06B5;
            6'd6:    m = 12'h05AD;
            6'd7:    m = 12'h056B;
            6'd8:    m = 12'h09AD;
            6'd9:    m = 12'h0AAD;
            6'd10:   m = 12'h029D;
            6'd11:   m = 12'h04E9;
            6'd12:   m = 12'h0B6D;
            6'd13:   m = 12'h06DB;
            6'd14:   m = 12'h0295;
            6'd15:   m = 12'h04A9;
            6'd16:   m = 12'h09B3;
            6'd17:   m = 12'h0AD3;
            6'd18:   m = 12'h09CB;
            6'd19:   m = 12'h0575;
            6'd20:   m = 12'h05BB;
            6'd21:   m = 12'h09CD;
            6'd22:   m = 12'h04A5;
            6'd23:   m = 12'h028D;
            6'd24:   m = 12'h018B;
            6'd25:   m = 12'h01A3;
            6'd26:   m = 12'h08B1;
            6'd27:   m = 12'h08C5;
            6'd28:   m = 12'h0481;
            6'd29:   m = 12'h0555;
            6'd30:   m = 12'h0249;
            6'd31:   m = 12'h0111;
            6'd32:   m = 12'h0421;
            6'd33:   m = 12'h0081;
            6'd34:   m = 12'h0001;
            default: m = FULL_MASK;
        endcase
        return m;
    endfunction

endpackage

### rtl/scale_pitch_quantizer_top.sv
// Channel   Signals                           Moves
// input     in_valid, in_ready, note_in       one note item
// output    out_valid, out_ready, note_out    one quantized note item
// config    cfg_we, cfg_index, cfg_data       register write, no handshake
// An accepted item passes through the five stage registers in order; out_valid shows the last one.
// A new item can be accepted every cycle while the output is not stalled.
// Reset clears the valid bits of all stages and sets both registers to zero.
// Each stage holds its item while the stage after it is full and stalled,
// so empty stages still fill while the output waits.
module scale_pitch_quantizer_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [spq_pkg::NOTE_IN_W-1:0]   note_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [spq_pkg::NOTE_OUT_W-1:0]  note_out,
    input  logic                                   cfg_we,
    input  logic [spq_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [spq_pkg::CFG_DATA_W-1:0]         cfg_data
);

    logic [spq_pkg::SEL_W-1:0]  scale_select_reg;
    logic [spq_pkg::ROOT_W-1:0] root_note_reg;

    logic [spq_pkg::STAGES-1:0] vld_reg;
    logic [spq_pkg::STAGES-1:0] en;

    // Stage 1 registers.
    logic signed [spq_pkg::NOTE_IN_W-1:0] note1_reg;
    logic [8:0]                           v1_reg;
    spq_pkg::mask_t                       mask1_reg;
    logic                                 pass1_reg;
    // Stage 2 registers.
    logic signed [spq_pkg::NOTE_IN_W-1:0] note2_reg;
    spq_pkg::pc_t                         pc2_reg;
    spq_pkg::mask_t                       mask2_reg;
    logic                                 pass2_reg;
    // Stage 3 registers.
    logic signed [spq_pkg::NOTE_IN_W-1:0] note3_reg;
    spq_pkg::mask_t                       rot3_reg;
    logic                                 pass3_reg;
    // Stage 4 registers.
    logic signed [spq_pkg::NOTE_IN_W-1:0] note4_reg;
    spq_pkg::offset_t                     off4_reg;
    // Stage 5 register.
    logic signed [spq_pkg::NOTE_OUT_W-1:0] note5_reg;

    logic [3:0]                            root_mod;
    spq_pkg::mask_t                        mask_next;
    logic                                  pass_next;
    logic [9:0]                            v_wide;
    logic [8:0]                            v_next;
    logic [16:0]                           prod;
    logic [4:0]                            quo;
    logic [8:0]                            rem_raw;
    spq_pkg::pc_t                          pc_next;
    logic [2*spq_pkg::PC_COUNT-1:0]        dbl;
    logic [2*spq_pkg::PC_COUNT-1:0]        dbl_shift;
    spq_pkg::mask_t                        rot_next;
    spq_pkg::offset_t                      off_next;
    logic signed [spq_pkg::NOTE_OUT_W-1:0] note_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_select_reg <= '0;
            root_note_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                spq_pkg::REG_SCALE_SELECT: scale_select_reg <= cfg_data;
                spq_pkg::REG_ROOT_NOTE:    root_note_reg    <= cfg_data[spq_pkg::ROOT_W-1:0];
                default:                   ;
            endcase
        end
    end

    // Each stage loads when it is empty or the stage after it loads.
    always_comb
    begin
        en[spq_pkg::STAGES-1] = !vld_reg[spq_pkg::STAGES-1] || out_ready;
        for (int k = spq_pkg::STAGES - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[spq_pkg::STAGES-1];
    assign note_out  = note5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < spq_pkg::STAGES; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 1: scale lookup and the biased note relative to the root.
    always_comb
    begin
        root_mod  = (root_note_reg >= 4'd12) ? (root_note_reg - 4'd12) : root_note_reg;
        mask_next = (32'(scale_select_reg) < spq_pkg::NUM_SCALES)
                    ? spq_pkg::rom_mask(scale_select_reg) : spq_pkg::FULL_MASK;
        pass_next = (mask_next == spq_pkg::FULL_MASK) || (mask_next == spq_pkg::EMPTY_MASK);
        v_wide    = {{2{note_in[spq_pkg::NOTE_IN_W-1]}}, note_in} + 10'd156
                    - {6'd0, root_mod};
        v_next    = v_wide[8:0];
    end

    // Stage 2: pitch class as the value modulo twelve, by reciprocal multiply.
    always_comb
    begin
        prod    = 17'(v1_reg) * 17'd171;
        quo     = prod[15:11];
        rem_raw = v1_reg - (9'(quo) * 9'd12);
        pc_next = (rem_raw >= 9'd12) ? 4'(rem_raw - 9'd12) : rem_raw[3:0];
    end

    // Stage 3: rotate the mask so bit d tells whether the note d above is in scale.
    always_comb
    begin
        dbl       = {mask2_reg, mask2_reg};
        dbl_shift = dbl >> pc2_reg;
        rot_next  = dbl_shift[spq_pkg::PC_COUNT-1:0];
    end

    // Stage 4: nearest member, the note above winning a tie.
    always_comb
    begin
        off_next = '0;
        for (int d = spq_pkg::PC_COUNT - 1; d >= 0; d--)
        begin
            if (rot3_reg[d])
            begin
                off_next = 5'(d);
            end
            else if (rot3_reg[(spq_pkg::PC_COUNT - d) % spq_pkg::PC_COUNT])
            begin
                off_next = 5'(-d);
            end
        end
        if (pass3_reg)
        begin
            off_next = '0;
        end
    end

    // Stage 5: apply the offset.
    assign note_next = {note4_reg[spq_pkg::NOTE_IN_W-1], note4_reg}
                       + {{4{off4_reg[4]}}, off4_reg};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            note1_reg <= note_in;
            v1_reg    <= v_next;
            mask1_reg <= mask_next;
            pass1_reg <= pass_next;
        end
        if (en[1])
        begin
            note2_reg <= note1_reg;
            pc2_reg   <= pc_next;
            mask2_reg <= mask1_reg;
            pass2_reg <= pass1_reg;
        end
        if (en[2])
        begin
            note3_reg <= note2_reg;
            rot3_reg  <= rot_next;
            pass3_reg <= pass2_reg;
        end
        if (en[3])
        begin
            note4_reg <= note3_reg;
            off4_reg  <= off_next;
        end
        if (en[4])
        begin
            note5_reg <= note_next;
        end
    end

    // The input stalls only when every stage holds an item.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (vld_reg == '1))
        else $error("input stalled with an empty stage");

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] |-> (pc2_reg < 4'd12))
        else $error("pitch class out of range");

    a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] |-> (off4_reg <= 5'sd6 && off4_reg >= -5'sd6))
        else $error("offset beyond six semitones");

    a_pass_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[2] && pass3_reg && en[3]) |=> (off4_reg == 5'sd0))
        else $error("pass-through item got a nonzero offset");

    a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[3] && en[4]) |=> (out_valid
            && note_out == $past(note4_reg) + $past(off4_reg)))
        else $error("output does not match the offset stage");

endmodule

### sim/scale_pitch_quantizer_top_tb.sv
module scale_pitch_quantizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int DIRECTED_ROWS = 21;
    localparam int PHASES        = 27;
    localparam int PHASE_ITEMS   = 50;

    // Scale masks, entry 34 in the top bits down to entry 0 in the bottom bits.
    localparam logic [spq_pkg::ROM_DEPTH*spq_pkg::PC_COUNT-1:0] MASK_ROM = {
        12'h001, 12'h081, 12'h421, 12'h111, 12'h249, 12'h555, 12'h481,
        12'h8C5, 12'h8B1, 12'h1A3, 12'h18B, 12'h28D, 12'h4A5, 12'h9CD,
        12'h5BB, 12'h575, 12'h9CB, 12'hAD3, 12'h9B3, 12'h4A9, 12'h295,
        12'h6DB, 12'hB6D, 12'h4E9, 12'h29D, 12'hAAD, 12'h9AD, 12'h56B,
        12'h5AD, 12'h6B5, 12'hAD5, 12'h5AB, 12'h6AD, 12'hAB5, 12'hFFF
    };

    typedef struct packed {
        logic [spq_pkg::SEL_W-1:0]             sel;
        logic [spq_pkg::ROOT_W-1:0]            root;
        logic signed [spq_pkg::NOTE_IN_W-1:0]  note;
        logic                                  checked;
        logic signed [spq_pkg::NOTE_OUT_W-1:0] want;
    } plan_row_t;

    typedef struct {
        logic signed [spq_pkg::NOTE_IN_W-1:0]  note;
        logic signed [spq_pkg::NOTE_OUT_W-1:0] want;
    } pending_note_t;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   in_valid = 1'b0;
    logic                                   in_ready;
    logic signed [spq_pkg::NOTE_IN_W-1:0]   note_in = '0;
    logic                                   out_valid;
    logic                                   out_ready = 1'b0;
    logic signed [spq_pkg::NOTE_OUT_W-1:0]  note_out;
    logic                                   cfg_we = 1'b0;
    logic [spq_pkg::CFG_IDX_W-1:0]          cfg_index = spq_pkg::REG_SCALE_SELECT;
    logic [spq_pkg::CFG_DATA_W-1:0]         cfg_data = '0;

    logic                                   row_checked = 1'b0;
    logic signed [spq_pkg::NOTE_OUT_W-1:0]  row_want = '0;

    logic [spq_pkg::SEL_W-1:0]              sel_reg = '0;
    logic [spq_pkg::ROOT_W-1:0]             root_reg = '0;
    bit                                     tx_fast = 1'b0;
    bit                                     rx_fast = 1'b0;
    int                                     err_count = 0;
    int                                     cycle_count = 0;
    pending_note_t                          expected_notes[$];

    scale_pitch_quantizer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .note_in   (note_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .note_out  (note_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit pc_hit(input logic [spq_pkg::PC_COUNT-1:0] mask, input int n,
                                  input int r);
        int pc;
        pc = (n - r + 156) % 12;
        return mask[4'(pc)];
    endfunction

    function automatic logic signed [spq_pkg::NOTE_OUT_W-1:0] quantize_note(
        input logic [spq_pkg::SEL_W-1:0] sel,
        input logic [spq_pkg::ROOT_W-1:0] root,
        input logic signed [spq_pkg::NOTE_IN_W-1:0] note
    );
        logic [spq_pkg::PC_COUNT-1:0] mask;
        int r;
        int s;
        int d;
        int res;
        bit found;
        r = int'(root) % 12;
        s = int'(note);
        res = s;
        found = 1'b0;
        if (int'(sel) < spq_pkg::NUM_SCALES && int'(sel) < spq_pkg::ROM_DEPTH)
            mask = MASK_ROM[9'(int'(sel) * spq_pkg::PC_COUNT) +: spq_pkg::PC_COUNT];
        else
            mask = spq_pkg::FULL_MASK;
        if (mask != spq_pkg::FULL_MASK && mask != spq_pkg::EMPTY_MASK)
        begin
            for (d = 0; d < 12 && !found; d++)
            begin
                if (pc_hit(mask, s + d, r))
                begin
                    res = s + d;
                    found = 1'b1;
                end
                else if (pc_hit(mask, s - d, r))
                begin
                    res = s - d;
                    found = 1'b1;
                end
            end
        end
        return res[spq_pkg::NOTE_OUT_W-1:0];
    endfunction

    function automatic plan_row_t directed_row(input int k);
        plan_row_t r;
        case (k)
            0:  r = '{6'd0,  4'd0,  8'sd0,    1'b1, 9'sd0};
            1:  r = '{6'd0,  4'd0,  8'sd127,  1'b1, 9'sd127};
            2:  r = '{6'd0,  4'd0,  -8'sd128, 1'b1, -9'sd128};
            3:  r = '{6'd0,  4'd0,  -8'sd1,   1'b1, -9'sd1};
            4:  r = '{6'd34, 4'd0,  8'sd127,  1'b1, 9'sd132};
            5:  r = '{6'd34, 4'd0,  -8'sd128, 1'b1, -9'sd132};
            6:  r = '{6'd34, 4'd0,  8'sd6,    1'b1, 9'sd12};
            7:  r = '{6'd34, 4'd0,  8'sd0,    1'b1, 9'sd0};
            8:  r = '{6'd35, 4'd5,  8'sd77,   1'b1, 9'sd77};
            9:  r = '{6'd63, 4'd11, -8'sd77,  1'b1, -9'sd77};
            10: r = '{6'd63, 4'd11, -8'sd128, 1'b1, -9'sd128};
            11: r = '{6'd1,  4'd0,  8'sd6,    1'b0, 9'sd0};
            12: r = '{6'd1,  4'd0,  8'sd1,    1'b0, 9'sd0};
            13: r = '{6'd1,  4'd12, 8'sd1,    1'b0, 9'sd0};
            14: r = '{6'd1,  4'd15, 8'sd4,    1'b0, 9'sd0};
            15: r = '{6'd1,  4'd15, 8'sd127,  1'b0, 9'sd0};
            16: r = '{6'd1,  4'd15, -8'sd128, 1'b0, 9'sd0};
            17: r = '{6'd33, 4'd11, -8'sd128, 1'b0, 9'sd0};
            18: r = '{6'd33, 4'd11, 8'sd127,  1'b0, 9'sd0};
            19: r = '{6'd29, 4'd6,  -8'sd85,  1'b0, 9'sd0};
            20: r = '{6'd17, 4'd3,  8'sd100,  1'b0, 9'sd0};
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d, cycle %0d", what, got, want, cycle_count);
        err_count++;
    endtask

    task automatic send_note(
        input logic signed [spq_pkg::NOTE_IN_W-1:0] n,
        input logic checked,
        input logic signed [spq_pkg::NOTE_OUT_W-1:0] want
    );
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        note_in     <= n;
        row_checked <= checked;
        row_want    <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_notes.size() != 0)
            @(posedge clk);
        repeat (spq_pkg::STAGES + 3) @(posedge clk);
    endtask

    task automatic write_config(input logic [spq_pkg::SEL_W-1:0] sel,
                                input logic [spq_pkg::ROOT_W-1:0] root);
        cfg_we    <= 1'b1;
        cfg_index <= spq_pkg::REG_SCALE_SELECT;
        cfg_data  <= spq_pkg::CFG_DATA_W'(sel);
        @(posedge clk);
        cfg_index <= spq_pkg::REG_ROOT_NOTE;
        cfg_data  <= spq_pkg::CFG_DATA_W'(root);
        @(posedge clk);
        cfg_we   <= 1'b0;
        sel_reg  = sel;
        root_reg = root;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        pending_note_t entry;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                entry.note = note_in;
                entry.want = row_checked ? row_want : quantize_note(sel_reg, root_reg, note_in);
                expected_notes.push_back(entry);
            end
            if (out_valid && out_ready)
            begin
                if (expected_notes.size() == 0)
                    report_mismatch("result with no item pending", int'(note_out), 0);
                else
                begin
                    entry = expected_notes.pop_front();
                    if (note_out !== entry.want)
                        report_mismatch($sformatf("note_out for note_in %0d", entry.note),
                                        int'(note_out), int'(entry.want));
                end
            end
        end
    end

    initial
    begin
        int stall;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = rx_fast ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        plan_row_t row;
        logic [spq_pkg::SEL_W-1:0] sel;
        logic [spq_pkg::ROOT_W-1:0] root;
        logic signed [spq_pkg::NOTE_IN_W-1:0] n;
        int k;
        int ph;
        int i;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIRECTED_ROWS; k++)
        begin
            row = directed_row(k);
            if (row.sel != sel_reg || row.root != root_reg)
            begin
                wait_idle();
                write_config(row.sel, row.root);
            end
            send_note(row.note, row.checked, row.want);
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0: begin sel = 6'd0;  root = 4'd15; end
                1: begin sel = 6'd63; root = 4'd0;  end
                2: begin sel = 6'd34; root = 4'd11; end
                3: begin sel = 6'd35; root = 4'd12; end
                default:
                begin
                    if ($urandom_range(0, 9) == 0)
                        sel = spq_pkg::SEL_W'($urandom_range(35, 63));
                    else
                        sel = spq_pkg::SEL_W'($urandom_range(0, 34));
                    root = spq_pkg::ROOT_W'($urandom_range(0, 15));
                end
            endcase
            write_config(sel, root);
            tx_fast = ($urandom_range(0, 3) == 0);
            rx_fast = ($urandom_range(0, 3) == 0);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                case ($urandom_range(0, 31))
                    0:       n = 8'sh7F;
                    1:       n = 8'sh80;
                    2:       n = 8'sh00;
                    3:       n = 8'shFF;
                    default: n = spq_pkg::NOTE_IN_W'($urandom_range(0, 255));
                endcase
                send_note(n, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (spq_pkg::STAGES + 5) @(posedge clk);
        if (expected_notes.size() != 0)
            report_mismatch("items left without a result", expected_notes.size(), 0);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
rtl/spq_pkg.sv
rtl/scale_pitch_quantizer_top.sv
sim/scale_pitch_quantizer_top_tb.sv
